/* rtl/core/fbpa_pkg.sv */
// Package for the fixed block pool allocator: field widths, status and mode
// codes, the controller command type and the lowest-free-chunk search.
// No dependencies.
`default_nettype none

package fbpa_pkg;

   localparam int NUM_POOLS_DEFAULT  = 4;
   localparam int MAX_CHUNKS_DEFAULT = 32;

   localparam int MODE_W   = 2;
   localparam int SIZE_W   = 16;
   localparam int RCOUNT_W = 8;
   localparam int NEED_W   = SIZE_W + RCOUNT_W;
   localparam int POOL_W   = 2;
   localparam int CHUNK_W  = 5;
   localparam int CNT_W    = 6;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MAP_W    = 32;

   localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COUNTED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADHANDLE = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // latch the request word
      logic exec;   // look up, update the busy map and load the response
   } ctrl_cmd_type;

   // Lowest set bit of a map word, found by halving in five steps.
   function automatic logic [CHUNK_W:0] lowest_set(input logic [MAP_W-1:0] vec);
      logic [MAP_W-1:0]   v;
      logic [CHUNK_W-1:0] idx;
      logic [MAP_W-1:0]   low_mask;
      v   = vec;
      idx = '0;
      for (int lvl = CHUNK_W - 1; lvl >= 0; lvl--) begin
         low_mask = (MAP_W'(1) << (1 << lvl)) - MAP_W'(1);
         if ((v & low_mask) == '0) begin
            idx[lvl] = 1'b1;
            v = v >> (1 << lvl);
         end
      end
      return {(|vec), idx};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/fbpa_req_if.sv */
// Request channel of the pool allocator: valid, ready and the request word.
// Depends on fbpa_pkg for the field widths.
`default_nettype none

interface fbpa_req_if;
   logic                                valid;
   logic                                ready;
   logic [fbpa_pkg::MODE_W-1:0]         mode;
   logic [fbpa_pkg::SIZE_W-1:0]         request_size;
   logic [fbpa_pkg::RCOUNT_W-1:0]       request_count;
   logic [fbpa_pkg::POOL_W-1:0]         free_pool;
   logic [fbpa_pkg::CHUNK_W-1:0]        free_chunk;

   modport source (output valid, mode, request_size, request_count, free_pool,
                   free_chunk, input ready);
   modport sink   (input valid, mode, request_size, request_count, free_pool,
                   free_chunk, output ready);
endinterface

`default_nettype wire

/* rtl/core/fbpa_rsp_if.sv */
// Response channel of the pool allocator: valid, ready and the result word.
// Depends on fbpa_pkg for the field widths.
`default_nettype none

interface fbpa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fbpa_pkg::STATUS_W-1:0]   status;
   logic [fbpa_pkg::POOL_W-1:0]     grant_pool;
   logic [fbpa_pkg::CHUNK_W-1:0]    grant_chunk;

   modport source (output valid, status, grant_pool, grant_chunk, input ready);
   modport sink   (input valid, status, grant_pool, grant_chunk, output ready);
endinterface

`default_nettype wire

/* rtl/core/fbpa_ctrl.sv */
// Controller of the pool allocator: two-state sequencer and response valid.
// Depends on fbpa_pkg for the command type.
`default_nettype none

module fbpa_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output fbpa_pkg::ctrl_cmd_type      cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // A new word may enter once the response register will be empty by the
   // time the lookup writes it.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign cmd.load  = req_valid && req_ready;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.exec) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fbpa_dp.sv */
// Datapath of the pool allocator: pool registers, busy map, request latch,
// chunk search and response register. Depends on fbpa_pkg.
`default_nettype none

module fbpa_dp #(
   parameter int NUM_POOLS  = fbpa_pkg::NUM_POOLS_DEFAULT,
   parameter int MAX_CHUNKS = fbpa_pkg::MAX_CHUNKS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire fbpa_pkg::ctrl_cmd_type             cmd,
   input  wire logic                               csr_wr_en,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [fbpa_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [fbpa_pkg::SIZE_W-1:0]        req_size,
   input  wire logic [fbpa_pkg::RCOUNT_W-1:0]      req_count,
   input  wire logic [fbpa_pkg::POOL_W-1:0]        req_free_pool,
   input  wire logic [fbpa_pkg::CHUNK_W-1:0]       req_free_chunk,
   output logic [fbpa_pkg::STATUS_W-1:0]           rsp_status,
   output logic [fbpa_pkg::POOL_W-1:0]             rsp_grant_pool,
   output logic [fbpa_pkg::CHUNK_W-1:0]            rsp_grant_chunk
);

   localparam int CHUNK_LIMIT = (MAX_CHUNKS < fbpa_pkg::MAP_W) ? MAX_CHUNKS
                                                               : fbpa_pkg::MAP_W;
   localparam logic [fbpa_pkg::CNT_W-1:0] LIMIT_CNT = fbpa_pkg::CNT_W'(CHUNK_LIMIT);

   logic [fbpa_pkg::SIZE_W-1:0]  size_ff  [NUM_POOLS];
   logic [fbpa_pkg::CNT_W-1:0]   count_ff [NUM_POOLS];
   logic [CHUNK_LIMIT-1:0]       busy_ff  [NUM_POOLS];
   logic [CHUNK_LIMIT-1:0]       busy_in  [NUM_POOLS];

   logic [fbpa_pkg::MODE_W-1:0]  mode_ff;
   logic [fbpa_pkg::NEED_W-1:0]  need_ff, need_in;
   logic [fbpa_pkg::POOL_W-1:0]  fpool_ff;
   logic [fbpa_pkg::CHUNK_W-1:0] fchunk_ff;

   logic [fbpa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [fbpa_pkg::POOL_W-1:0]   gpool_ff, gpool_in;
   logic [fbpa_pkg::CHUNK_W-1:0]  gchunk_ff, gchunk_in;

   logic [fbpa_pkg::CNT_W-1:0]   cnt_eff   [NUM_POOLS];
   logic [CHUNK_LIMIT-1:0]       free_vec  [NUM_POOLS];
   logic [fbpa_pkg::CHUNK_W:0]   search    [NUM_POOLS];
   logic [NUM_POOLS-1:0]         pool_fit;

   // The product is formed at full width so that a counted request never wraps.
   assign need_in = (req_mode == fbpa_pkg::MODE_COUNTED)
                  ? fbpa_pkg::NEED_W'(req_size) * fbpa_pkg::NEED_W'(req_count)
                  : fbpa_pkg::NEED_W'(req_size);

   always_comb begin
      for (int p = 0; p < NUM_POOLS; p++) begin
         cnt_eff[p] = (count_ff[p] > LIMIT_CNT) ? LIMIT_CNT : count_ff[p];
         for (int c = 0; c < CHUNK_LIMIT; c++) begin
            free_vec[p][c] = !busy_ff[p][c] && (fbpa_pkg::CNT_W'(c) < cnt_eff[p]);
         end
         search[p]   = fbpa_pkg::lowest_set(fbpa_pkg::MAP_W'(free_vec[p]));
         pool_fit[p] = (need_ff <= fbpa_pkg::NEED_W'(size_ff[p]))
                     && search[p][fbpa_pkg::CHUNK_W];
      end
   end

   always_comb begin
      logic                           found;
      logic [fbpa_pkg::CNT_W-1:0]     fcnt;
      logic                           fbusy;
      logic                           handle_ok;
      found     = 1'b0;
      fcnt      = '0;
      fbusy     = 1'b0;
      status_in = fbpa_pkg::ST_NOFIT;
      gpool_in  = '0;
      gchunk_in = '0;
      for (int p = 0; p < NUM_POOLS; p++) begin
         busy_in[p] = busy_ff[p];
      end

      for (int p = 0; p < NUM_POOLS; p++) begin
         if (fpool_ff == fbpa_pkg::POOL_W'(p)) begin
            fcnt = cnt_eff[p];
            for (int c = 0; c < CHUNK_LIMIT; c++) begin
               if (fchunk_ff == fbpa_pkg::CHUNK_W'(c)) fbusy = busy_ff[p][c];
            end
         end
      end
      handle_ok = ({1'b0, fpool_ff} < (fbpa_pkg::POOL_W + 1)'(NUM_POOLS))
               && ({1'b0, fchunk_ff} < fcnt);

      case (mode_ff)
         fbpa_pkg::MODE_ALLOC, fbpa_pkg::MODE_COUNTED: begin
            for (int p = 0; p < NUM_POOLS; p++) begin
               if (!found && pool_fit[p]) begin
                  found     = 1'b1;
                  status_in = fbpa_pkg::ST_GRANTED;
                  gpool_in  = fbpa_pkg::POOL_W'(p);
                  gchunk_in = search[p][fbpa_pkg::CHUNK_W-1:0];
                  for (int c = 0; c < CHUNK_LIMIT; c++) begin
                     if (search[p][fbpa_pkg::CHUNK_W-1:0] == fbpa_pkg::CHUNK_W'(c)) begin
                        busy_in[p][c] = 1'b1;
                     end
                  end
               end
            end
         end
         fbpa_pkg::MODE_FREE: begin
            if (!handle_ok) begin
               status_in = fbpa_pkg::ST_BADHANDLE;
            end else if (fbusy) begin
               status_in = fbpa_pkg::ST_FREED;
               for (int p = 0; p < NUM_POOLS; p++) begin
                  for (int c = 0; c < CHUNK_LIMIT; c++) begin
                     if (fpool_ff == fbpa_pkg::POOL_W'(p)
                         && fchunk_ff == fbpa_pkg::CHUNK_W'(c)) begin
                        busy_in[p][c] = 1'b0;
                     end
                  end
               end
            end else begin
               status_in = fbpa_pkg::ST_ALREADY;
            end
         end
         default: status_in = fbpa_pkg::ST_NOFIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_POOLS; p++) begin
            size_ff[p]  <= '0;
            count_ff[p] <= '0;
            busy_ff[p]  <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            for (int p = 0; p < NUM_POOLS; p++) begin
               if (csr_index == fbpa_pkg::CSR_IDX_W'(2 * p)) begin
                  size_ff[p] <= csr_wdata;
               end
               if (csr_index == fbpa_pkg::CSR_IDX_W'(2 * p + 1)) begin
                  count_ff[p] <= csr_wdata[fbpa_pkg::CNT_W-1:0];
               end
            end
         end
         if (cmd.exec) begin
            for (int p = 0; p < NUM_POOLS; p++) begin
               busy_ff[p] <= busy_in[p];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         need_ff   <= need_in;
         fpool_ff  <= req_free_pool;
         fchunk_ff <= req_free_chunk;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         gpool_ff  <= gpool_in;
         gchunk_ff <= gchunk_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_grant_pool  = gpool_ff;
   assign rsp_grant_chunk = gchunk_ff;

endmodule

`default_nettype wire

/* rtl/core/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator: controller and datapath.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if, fbpa_ctrl and fbpa_dp.
//
//   port      dir     width  role
//   req_ch    sink    33     request word: mode, size, count, free handle
//   rsp_ch    source  10     response word: status, granted pool and chunk
//   csr_*     in      3+16   pool size and count register writes
//
// A word is latched when accepted, and in the next cycle the fit compare,
// the lowest-free-chunk search and the busy map update run together and
// load the response register. The busy map sits in flip-flops and is
// cleared by the synchronous reset, with no sweep. A stalled response holds
// its register; a new word is taken once the response is accepted or in
// the same cycle.
`default_nettype none

module fixed_block_pool_allocator #(
   parameter int NUM_POOLS  = fbpa_pkg::NUM_POOLS_DEFAULT,
   parameter int MAX_CHUNKS = fbpa_pkg::MAX_CHUNKS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   fbpa_req_if.sink                                req_ch,
   fbpa_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_wr_en,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   fbpa_pkg::ctrl_cmd_type cmd;
   logic                   req_ready;
   logic                   rsp_valid;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   fbpa_dp #(
      .NUM_POOLS  (NUM_POOLS),
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_mode        (req_ch.mode),
      .req_size        (req_ch.request_size),
      .req_count       (req_ch.request_count),
      .req_free_pool   (req_ch.free_pool),
      .req_free_chunk  (req_ch.free_chunk),
      .rsp_status      (rsp_ch.status),
      .rsp_grant_pool  (rsp_ch.grant_pool),
      .rsp_grant_chunk (rsp_ch.grant_chunk)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

`default_nettype wire
